FILE: rtl/decimal_scale_aligner_unit_macros.svh
// ----------------------------------------------------------------------------
// decimal scale aligner assertion macros
// shared concurrent assertion wrappers, clocked on clk_i
// ----------------------------------------------------------------------------
`ifndef DECIMAL_SCALE_ALIGNER_UNIT_MACROS_SVH
`define DECIMAL_SCALE_ALIGNER_UNIT_MACROS_SVH

// checked only out of reset
`define DSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked on every edge, reset included
`define DSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// types and constants shared by the decimal scale aligner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsa_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned MANT_W        = 3 * WORD_W;
  localparam int unsigned SCALE_W       = 5;
  localparam int unsigned PROD_W        = MANT_W + 4;
  localparam int unsigned FIELD_W       = MANT_W + SCALE_W;
  localparam int unsigned DATA_W        = ((2 * FIELD_W + 7) / 8) * 8;
  localparam int unsigned PAD_W         = DATA_W - 2 * FIELD_W;
  localparam int unsigned A_SCALE_LSB   = MANT_W;
  localparam int unsigned B_SCALE_LSB   = FIELD_W + MANT_W;
  localparam int unsigned DEF_MAX_SCALE = 28;

  // inverse of five modulo two to the word width
  localparam logic [WORD_W-1:0] INV5 = 32'hCCCC_CCCD;

  typedef enum logic [1:0] {
    CH_LOW  = 2'd0,
    CH_MID  = 2'd1,
    CH_HIGH = 2'd2
  } chunk_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_TEST,
    ST_DIV_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic div_start;
    logic div_chunk;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic lt;
    logic mul_ovf;
    logic exact;
    logic last_chunk;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/dsa_ctrl.sv
// ----------------------------------------------------------------------------
// dsa_ctrl
// sequencer for the multiply and exact divide phases of scale alignment
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsa_ctrl
  import dsa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        if (status_i.bad || !status_i.lt) begin
          state_d = ST_DONE;
        end else if (status_i.mul_ovf) begin
          state_d = ST_DIV_TEST;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      ST_DIV_TEST: begin
        if (!status_i.lt || !status_i.exact) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV_RUN;
        end
      end
      ST_DIV_RUN: begin
        cmd_o.div_chunk = 1'b1;
        if (status_i.last_chunk) begin
          state_d = ST_DIV_TEST;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/dsa_datapath.sv
// ----------------------------------------------------------------------------
// dsa_datapath
// operand registers, times-ten unit, word-serial exact divide by ten and
// output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsa_datapath
  import dsa_pkg::*;
#(
  parameter int unsigned MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic [DATA_W-1:0] in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o,
  output logic              out_ovf_o
);

  localparam int unsigned HW_N = MANT_W / 16;

  // divisible by ten: even and halfword then nibble digit sum divisible by five
  function automatic logic is_div10(input logic [MANT_W-1:0] x);
    logic [19:0] hs;
    logic [6:0]  ns;
    logic [14:0] pr;
    logic [6:0]  r;
    hs = '0;
    for (int i = 0; i < HW_N; i++) begin
      hs = hs + 20'(x[16*i +: 16]);
    end
    ns = '0;
    for (int j = 0; j < 5; j++) begin
      ns = ns + 7'(hs[4*j +: 4]);
    end
    pr = 15'(ns) * 15'd205;
    r  = ns - 7'({pr[14:10], 2'b00}) - 7'(pr[14:10]);
    return (x[0] == 1'b0) && (r == 7'd0);
  endfunction

  logic [MANT_W-1:0]  orig_a_q, orig_b_q;
  logic [SCALE_W-1:0] orig_sa_q, orig_sb_q;
  logic [MANT_W-1:0]  lo_q, hi_q;
  logic [SCALE_W-1:0] lo_sc_q, hi_sc_q;
  logic               swap_q, bad_q;
  logic [MANT_W-1:0]  rem_q;
  logic [2*WORD_W-1:0] quo_q;
  chunk_e             chunk_q;
  logic               out_valid_q;
  logic [DATA_W-1:0]  out_data_q;
  logic               out_ovf_q;

  logic [MANT_W-1:0]   in_a, in_b;
  logic [SCALE_W-1:0]  in_sa, in_sb;
  logic [PROD_W-1:0]   prod;
  logic [2*WORD_W-1:0] inv_prod;
  logic [WORD_W-1:0]   q32;
  logic [WORD_W+2:0]   q5;
  logic [MANT_W-1:0]   diff;
  logic                ok;
  logic [FIELD_W-1:0]  ra_f, rb_f;

  assign in_a  = in_data_i[0 +: MANT_W];
  assign in_sa = in_data_i[A_SCALE_LSB +: SCALE_W];
  assign in_b  = in_data_i[FIELD_W +: MANT_W];
  assign in_sb = in_data_i[B_SCALE_LSB +: SCALE_W];

  assign prod     = PROD_W'({lo_q, 3'b000}) + PROD_W'({lo_q, 1'b0});
  assign inv_prod = {{WORD_W{1'b0}}, rem_q[WORD_W-1:0]} * {{WORD_W{1'b0}}, INV5};
  assign q32      = inv_prod[WORD_W-1:0];
  assign q5       = {1'b0, q32, 2'b00} + {3'b000, q32};
  assign diff     = rem_q - MANT_W'(q5);

  assign ok = !bad_q && (lo_sc_q == hi_sc_q);

  always_comb begin
    if (ok) begin
      if (swap_q) begin
        ra_f = {hi_sc_q, hi_q};
        rb_f = {lo_sc_q, lo_q};
      end else begin
        ra_f = {lo_sc_q, lo_q};
        rb_f = {hi_sc_q, hi_q};
      end
    end else begin
      ra_f = {orig_sa_q, orig_a_q};
      rb_f = {orig_sb_q, orig_b_q};
    end
  end

  assign status_o.bad        = bad_q;
  assign status_o.lt         = lo_sc_q < hi_sc_q;
  assign status_o.mul_ovf    = prod[PROD_W-1:MANT_W] != '0;
  assign status_o.exact      = is_div10(hi_q);
  assign status_o.last_chunk = chunk_q == CH_HIGH;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      chunk_q     <= CH_LOW;
    end else begin
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.div_start) begin
        chunk_q <= CH_LOW;
      end else if (cmd_i.div_chunk) begin
        case (chunk_q)
          CH_LOW:  chunk_q <= CH_MID;
          CH_MID:  chunk_q <= CH_HIGH;
          default: chunk_q <= CH_LOW;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      orig_a_q  <= in_a;
      orig_b_q  <= in_b;
      orig_sa_q <= in_sa;
      orig_sb_q <= in_sb;
      swap_q    <= in_sa > in_sb;
      bad_q     <= (in_sa > SCALE_W'(MAX_SCALE)) || (in_sb > SCALE_W'(MAX_SCALE));
      if (in_sa > in_sb) begin
        lo_q    <= in_b;
        lo_sc_q <= in_sb;
        hi_q    <= in_a;
        hi_sc_q <= in_sa;
      end else begin
        lo_q    <= in_a;
        lo_sc_q <= in_sa;
        hi_q    <= in_b;
        hi_sc_q <= in_sb;
      end
    end
    if (cmd_i.mul_step) begin
      lo_q    <= prod[MANT_W-1:0];
      lo_sc_q <= lo_sc_q + SCALE_W'(1);
    end
    if (cmd_i.div_start) begin
      rem_q <= {1'b0, hi_q[MANT_W-1:1]};
    end
    if (cmd_i.div_chunk) begin
      rem_q <= {{WORD_W{1'b0}}, diff[MANT_W-1:WORD_W]};
      case (chunk_q)
        CH_LOW:  quo_q[0 +: WORD_W]      <= q32;
        CH_MID:  quo_q[WORD_W +: WORD_W] <= q32;
        default: begin
          hi_q    <= {q32, quo_q};
          hi_sc_q <= hi_sc_q - SCALE_W'(1);
        end
      endcase
    end
    if (cmd_i.finish) begin
      out_data_q <= {{PAD_W{1'b0}}, rb_f, ra_f};
      out_ovf_q  <= !ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_ovf_o   = out_ovf_q;

endmodule

FILE: rtl/decimal_scale_aligner_unit.sv
// ----------------------------------------------------------------------------
// decimal_scale_aligner_unit
// brings two 96-bit decimal mantissas to a common scale by multiplying the
// lower-scale one by ten, then dividing the higher-scale one by ten while exact
// ----------------------------------------------------------------------------
//  channel   dir  beat payload
//  s_axis    in   a words, a scale, b words, b scale
//  m_axis    out  aligned a, aligned b, overflow flag in tuser
//
// one operand pair in flight; a beat takes m times-ten steps if times-ten alone
// aligns, else m times-ten steps and then d exact divide steps, each a test
// plus three 32-bit word steps, m + d at most 28
// the next beat is accepted once the result sits in the output register
// a stalled result only holds the sequencer at its final step
// rst_ni clears the sequencer and the output valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_scale_aligner_unit
  import dsa_pkg::*;
#(
  parameter int unsigned MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // a_word0, a_word1, a_word2, a_scale, b_word0, b_word1, b_word2, b_scale
  input  logic [DATA_W-1:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // ra_word0, ra_word1, ra_word2, ra_scale, rb_word0, rb_word1, rb_word2, rb_scale
  output logic [DATA_W-1:0] m_axis_tdata,
  // overflow
  output logic              m_axis_tuser
);

  cmd_t    cmd;
  status_t status;

  dsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dsa_datapath #(
    .MAX_SCALE (MAX_SCALE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_ovf_o   (m_axis_tuser)
  );

endmodule

FILE: rtl/dsa_checker.sv
// ----------------------------------------------------------------------------
// dsa_checker
// port-level checks on the decimal scale aligner, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "decimal_scale_aligner_unit_macros.svh"

module dsa_checker
  import dsa_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [DATA_W-1:0] s_axis_tdata,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic              m_axis_tuser
);

  `DSA_ASSERT_ALWAYS(a_no_beat_in_reset, !rst_ni |-> !m_axis_tvalid, "result beat in reset")

  `DSA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  `DSA_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")

  `DSA_ASSERT(a_result_after_busy, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result without prior work")

  `DSA_ASSERT(a_aligned_scales, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[A_SCALE_LSB +: SCALE_W] == m_axis_tdata[B_SCALE_LSB +: SCALE_W], "scales differ without overflow")

endmodule

bind decimal_scale_aligner_unit dsa_checker u_dsa_checker (.*);

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for decimal_scale_aligner_unit: operand pairs are
// streamed in from a queue, each accepted beat is aligned by a behavioral
// model and the expected beat is compared field by field with the output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import dsa_pkg::*;

  localparam int unsigned SCALE_LIMIT = DEF_MAX_SCALE;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              ovf;
  } aligned_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // a_word0, a_word1, a_word2, a_scale, b_word0, b_word1, b_word2, b_scale
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // ra_word0, ra_word1, ra_word2, ra_scale, rb_word0, rb_word1, rb_word2, rb_scale
  logic [DATA_W-1:0] m_axis_tdata;
  // overflow
  logic              m_axis_tuser;

  logic [DATA_W-1:0] operand_q[$];
  aligned_t          aligned_q[$];
  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct = 0;
  int unsigned       mismatch_cnt = 0;
  logic              hold_req = 1'b0;
  logic              rx_hold = 1'b0;

  decimal_scale_aligner_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [MANT_W-1:0] ten_pow(input int unsigned k);
    logic [MANT_W-1:0] p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  function automatic logic [DATA_W-1:0] pack_pair(input logic [MANT_W-1:0] am,
                                                  input logic [SCALE_W-1:0] as,
                                                  input logic [MANT_W-1:0] bm,
                                                  input logic [SCALE_W-1:0] bs);
    logic [DATA_W-1:0] d;
    d = '0;
    d[0 +: MANT_W] = am;
    d[A_SCALE_LSB +: SCALE_W] = as;
    d[FIELD_W +: MANT_W] = bm;
    d[B_SCALE_LSB +: SCALE_W] = bs;
    return d;
  endfunction

  // raise the lower scale by times-ten, then lower the higher one by exact tenths
  function automatic aligned_t align_scales(input logic [DATA_W-1:0] d);
    logic [MANT_W-1:0]   am, bm, lo, hi;
    logic [SCALE_W-1:0]  as, bs;
    int unsigned         lo_s, hi_s;
    logic [MANT_W+3:0]   prod;
    logic                ok, a_low;
    aligned_t            r;
    am = d[0 +: MANT_W];
    as = d[A_SCALE_LSB +: SCALE_W];
    bm = d[FIELD_W +: MANT_W];
    bs = d[B_SCALE_LSB +: SCALE_W];
    ok = 1'b1;
    r.data = d;
    r.ovf = 1'b0;
    if (as > SCALE_LIMIT || bs > SCALE_LIMIT) begin
      ok = 1'b0;
    end else if (as != bs) begin
      a_low = (as < bs);
      lo = a_low ? am : bm;
      hi = a_low ? bm : am;
      lo_s = a_low ? as : bs;
      hi_s = a_low ? bs : as;
      while (lo_s < hi_s) begin
        prod = {4'b0000, lo} * 100'd10;
        if (prod[MANT_W +: 4] != 0) break;
        lo = prod[MANT_W-1:0];
        lo_s++;
      end
      while (lo_s < hi_s && hi % 10 == 0) begin
        hi = hi / 10;
        hi_s--;
      end
      ok = (lo_s == hi_s);
      if (ok) begin
        r.data = a_low ? pack_pair(lo, SCALE_W'(lo_s), hi, SCALE_W'(hi_s))
                       : pack_pair(hi, SCALE_W'(hi_s), lo, SCALE_W'(lo_s));
      end
    end
    if (!ok) r.ovf = 1'b1;
    return r;
  endfunction

  function automatic logic [MANT_W-1:0] rand_mant();
    logic [MANT_W-1:0] m;
    m = {$urandom, $urandom, $urandom};
    case ($urandom_range(4))
      0: ;
      1: m = m >> $urandom_range(95);
      2: m = (m >> $urandom_range(95, 40)) * ten_pow($urandom_range(16));
      3: m = ten_pow($urandom_range(28)) * $urandom_range(99);
      default: m = m >> $urandom_range(95, 60);
    endcase
    return m;
  endfunction

  function automatic logic [SCALE_W-1:0] rand_scale();
    if ($urandom_range(39) == 0) return SCALE_W'($urandom_range(31, SCALE_LIMIT + 1));
    return SCALE_W'($urandom_range(SCALE_LIMIT));
  endfunction

  function automatic logic [DATA_W-1:0] rand_pair();
    logic [SCALE_W-1:0] as, bs;
    as = rand_scale();
    bs = ($urandom_range(9) == 0) ? as : rand_scale();
    return pack_pair(rand_mant(), as, rand_mant(), bs);
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                             input logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_cnt++;
      $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  task automatic check_beat(input aligned_t exp_b, input logic [DATA_W-1:0] act_d,
                            input logic act_ovf);
    string side;
    for (int s = 0; s < 2; s++) begin
      side = (s == 0) ? "ra" : "rb";
      for (int w = 0; w < 3; w++) begin
        check_field($sformatf("%s_word%0d", side, w),
                    exp_b.data[s*FIELD_W + w*WORD_W +: WORD_W],
                    act_d[s*FIELD_W + w*WORD_W +: WORD_W]);
      end
      check_field($sformatf("%s_scale", side),
                  WORD_W'(exp_b.data[s*FIELD_W + MANT_W +: SCALE_W]),
                  WORD_W'(act_d[s*FIELD_W + MANT_W +: SCALE_W]));
    end
    check_field("overflow", WORD_W'(exp_b.ovf), WORD_W'(act_ovf));
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (operand_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata <= operand_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off while the sender keeps offering beats
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // monitor
  always @(posedge clk_i) begin
    aligned_t exp_b;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) aligned_q.push_back(align_scales(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (aligned_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t unexpected beat expected none actual %h %b", $time,
                   m_axis_tdata, m_axis_tuser);
        end else begin
          exp_b = aligned_q.pop_front();
          check_beat(exp_b, m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  task automatic wait_drain();
    while (operand_q.size() > 0 || s_axis_tvalid || aligned_q.size() > 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    logic [MANT_W-1:0] all1;
    rst_ni <= 1'b0;
    all1 = '1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    operand_q.push_back(pack_pair('0, 0, '0, 0));
    operand_q.push_back(pack_pair(all1, 28, all1, 28));
    operand_q.push_back(pack_pair(1, 0, 1, 28));
    operand_q.push_back(pack_pair(7, 28, 3, 0));
    operand_q.push_back(pack_pair(all1, 0, 1, 5));
    operand_q.push_back(pack_pair(all1, 0, ten_pow(5), 5));
    operand_q.push_back(pack_pair(all1, 0, 1200, 3));
    operand_q.push_back(pack_pair(96'h1 << 90, 2, 1000, 10));
    operand_q.push_back(pack_pair(ten_pow(28), 28, all1, 0));
    operand_q.push_back(pack_pair(all1, 0, ten_pow(28) * 7, 28));
    operand_q.push_back(pack_pair('0, 0, '0, 28));
    operand_q.push_back(pack_pair(123, 29, 456, 29));
    operand_q.push_back(pack_pair(5, 31, 5, 0));
    operand_q.push_back(pack_pair(5, 0, 5, 30));
    operand_q.push_back(pack_pair({3{32'hAAAA_AAAA}}, 16, {3{32'h5555_5555}}, 15));
    operand_q.push_back(pack_pair({3{32'h5555_5555}}, 1, {3{32'hAAAA_AAAA}}, 1));
    operand_q.push_back(pack_pair(ten_pow(27) + 1, 27, 9, 13));
    operand_q.push_back(pack_pair(ten_pow(10) * 3, 20, 12345, 4));
    operand_q.push_back(pack_pair(all1 / 10, 3, 1, 4));
    operand_q.push_back(pack_pair(all1 / 10 + 1, 3, 1, 4));
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      for (int n = 0; n < 190; n++) operand_q.push_back(rand_pair());
      wait_drain();
    end

    // offer back-to-back beats against a held output
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    for (int n = 0; n < 40; n++) operand_q.push_back(rand_pair());
    wait_drain();

    repeat (150) @(posedge clk_i);
    if (mismatch_cnt == 0 && aligned_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/dsa_pkg.sv
rtl/dsa_ctrl.sv
rtl/dsa_datapath.sv
rtl/decimal_scale_aligner_unit.sv
rtl/dsa_checker.sv
tb/sv/testbench.sv
